// ===== src/dclr_pkg.sv =====
package dclr_pkg;

    localparam int RING_DEPTH_DEF    = 16384;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 44;
    localparam int STEP_W    = 17;
    localparam int STEP_FRAC = 16;

    localparam logic [STEP_W-1:0] SLOW_STEP_RST = STEP_W'(64881);
    localparam logic [STEP_W-1:0] FAST_STEP_RST = STEP_W'(66191);

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_PLAY  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        RATE_NOMINAL = 2'd0,
        RATE_SLOW    = 2'd1,
        RATE_FAST    = 2'd2
    } t_rate_mode;

    typedef enum logic [0:0] {
        CFG_SLOW_STEP = 1'b0,
        CFG_FAST_STEP = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_op                 op;
        logic [SAMPLE_W-1:0] sample;
        t_rate_mode          mode;
    } t_item;

endpackage

// ===== src/drift_corrected_linear_resampler.sv =====
// Channel   Handshake            Beat contents
// input     i_valid / o_ready    i_op, i_sample_in, i_now_ms, i_frame_time_ms
// output    o_valid / i_ready    o_sample_out, o_rate_mode
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One beat is taken per cycle while the output is not stalled; the dual-read ring lets
// a play beat fetch both neighbouring samples together, and a play result passes through
// the queue, the ring-read, product and output registers. Write beats give no result.
// Reset is synchronous; there is no clearing pass, as the write pointer and a wrap flag mark
// which ring entries hold data, and unwritten entries read as zero.
// A stalled output freezes the back end; a two-beat queue lets the input take two more beats.
module drift_corrected_linear_resampler
    import dclr_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [STEP_W-1:0]   i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  logic [SAMPLE_W-1:0] i_sample_in,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [TIME_W-1:0]   i_frame_time_ms,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample_out,
    output logic [1:0]          o_rate_mode
);

    logic       w_q_valid;
    t_item      w_q_item;
    logic       w_q_pop;
    t_rate_mode w_rate_mode;

    dclr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (t_op'(i_op)),
        .i_sample_in     (i_sample_in),
        .i_now_ms        (i_now_ms),
        .i_frame_time_ms (i_frame_time_ms),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_q_pop         (w_q_pop)
    );

    dclr_back #(
        .RING_DEPTH    (RING_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_rate_mode  (w_rate_mode)
    );

    assign o_rate_mode = w_rate_mode;

endmodule

// ===== src/dclr_front.sv =====
module dclr_front
    import dclr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_op                 i_op,
    input  logic [SAMPLE_W-1:0] i_sample_in,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [TIME_W-1:0]   i_frame_time_ms,
    output logic                o_q_valid,
    output t_item               o_q_item,
    input  logic                i_q_pop
);

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_item      w_item;
    logic       w_push;

    // The timing decision is taken here so that the back end only selects a step.
    always_comb begin
        w_item.op     = i_op;
        w_item.sample = i_sample_in;
        if (i_now_ms > i_frame_time_ms) begin
            w_item.mode = RATE_SLOW;
        end else if (i_now_ms < i_frame_time_ms) begin
            w_item.mode = RATE_FAST;
        end else begin
            w_item.mode = RATE_NOMINAL;
        end
    end

    assign o_ready   = !r_cnt[1];
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ===== src/dclr_back.sv =====
module dclr_back
    import dclr_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [STEP_W-1:0]   i_cfg_data,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample_out,
    output t_rate_mode          o_rate_mode
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int PW     = AW + FRACTION_BITS;
    localparam int SW     = PW + 1;
    localparam int SHL    = (FRACTION_BITS >= STEP_FRAC) ? FRACTION_BITS - STEP_FRAC : 0;
    localparam int SHR    = (FRACTION_BITS >= STEP_FRAC) ? 0 : STEP_FRAC - FRACTION_BITS;
    localparam int PROD_W = SAMPLE_W + FRACTION_BITS + 2;

    localparam logic [SW-1:0]     SPAN = SW'(RING_DEPTH) << FRACTION_BITS;
    localparam logic [SW-1:0]     ONE  = SW'(1) << FRACTION_BITS;
    localparam logic [AW-1:0]     LAST = AW'(RING_DEPTH - 1);
    localparam logic [PROD_W-1:0] BIAS = PROD_W'((1 << FRACTION_BITS) - 1);

    logic [STEP_W-1:0]   r_slow_step;
    logic [STEP_W-1:0]   r_fast_step;
    logic [AW-1:0]       r_wp;
    logic                r_wrapped;
    logic [PW-1:0]       r_phase;
    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_rd0;
    logic [SAMPLE_W-1:0] r_rd1;

    logic                     r_s1_vld;
    logic                     r_s1_v0;
    logic                     r_s1_v1;
    logic [FRACTION_BITS-1:0] r_s1_frac;
    t_rate_mode               r_s1_mode;

    logic                       r_s2_vld;
    logic signed [SAMPLE_W-1:0] r_s2_y0;
    logic signed [PROD_W-1:0]   r_s2_prod;
    t_rate_mode                 r_s2_mode;

    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out_sample;
    t_rate_mode          r_out_mode;

    logic                       w_adv;
    logic                       w_wr;
    logic                       w_rd;
    logic [AW-1:0]              w_x0;
    logic [AW-1:0]              w_x1;
    logic [AW-1:0]              n_wp;
    logic [SW-1:0]              w_step;
    logic [SW-1:0]              w_sum;
    logic [PW-1:0]              n_phase;
    logic signed [SAMPLE_W-1:0] w_y0;
    logic signed [SAMPLE_W-1:0] w_y1;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [FRACTION_BITS:0] w_frac;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_acc;
    logic signed [PROD_W-1:0]   w_biased;

    // The whole back end moves together whenever the output register can take a beat.
    assign w_adv   = !r_out_vld || i_ready;
    assign o_q_pop = w_adv && i_q_valid;
    assign w_wr    = o_q_pop && (i_q_item.op == OP_WRITE);
    assign w_rd    = o_q_pop && (i_q_item.op == OP_PLAY);

    assign w_x0 = r_phase[PW-1:FRACTION_BITS];
    assign w_x1 = (w_x0 == LAST) ? '0 : w_x0 + AW'(1);
    assign n_wp = (r_wp == LAST) ? '0 : r_wp + AW'(1);

    always_comb begin
        case (i_q_item.mode)
            RATE_SLOW: w_step = SW'(r_slow_step >> SHR) << SHL;
            RATE_FAST: w_step = SW'(r_fast_step >> SHR) << SHL;
            default:   w_step = ONE;
        endcase
        w_sum   = {1'b0, r_phase} + w_step;
        n_phase = (w_sum >= SPAN) ? PW'(w_sum - SPAN) : PW'(w_sum);
    end

    // Entries the write pointer has not yet reached read as zero.
    always_comb begin
        w_y0     = r_s1_v0 ? $signed(r_rd0) : '0;
        w_y1     = r_s1_v1 ? $signed(r_rd1) : '0;
        w_diff   = (SAMPLE_W + 1)'(w_y1) - (SAMPLE_W + 1)'(w_y0);
        w_frac   = $signed({1'b0, r_s1_frac});
        w_prod   = w_diff * w_frac;
        w_acc    = (PROD_W'(r_s2_y0) <<< FRACTION_BITS) + r_s2_prod;
        w_biased = w_acc[PROD_W-1] ? w_acc + $signed(BIAS) : w_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_step <= SLOW_STEP_RST;
            r_fast_step <= FAST_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_SLOW_STEP: r_slow_step <= i_cfg_data;
                CFG_FAST_STEP: r_fast_step <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_phase   <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_wr) begin
                r_wp <= n_wp;
                if (r_wp == LAST) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (w_rd) begin
                r_phase <= n_phase;
            end
            if (w_adv) begin
                r_s1_vld  <= w_rd;
                r_s2_vld  <= r_s1_vld;
                r_out_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ring[r_wp] <= i_q_item.sample;
        end
        if (w_rd) begin
            r_rd0 <= r_ring[w_x0];
            r_rd1 <= r_ring[w_x1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_v0      <= r_wrapped || (w_x0 < r_wp);
            r_s1_v1      <= r_wrapped || (w_x1 < r_wp);
            r_s1_frac    <= r_phase[FRACTION_BITS-1:0];
            r_s1_mode    <= i_q_item.mode;
            r_s2_y0      <= w_y0;
            r_s2_prod    <= w_prod;
            r_s2_mode    <= r_s1_mode;
            r_out_sample <= w_biased[FRACTION_BITS +: SAMPLE_W];
            r_out_mode   <= r_s2_mode;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out_sample;
    assign o_rate_mode  = r_out_mode;

endmodule
